// ----- src/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/vc3d_pkg.sv -----
package vc3d_pkg;
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_VOXEL = 1'b1;

	localparam logic [1:0] CFG_HALF  = 2'd0;
	localparam logic [1:0] CFG_DIM_X = 2'd1;
	localparam logic [1:0] CFG_DIM_Y = 2'd2;
	localparam logic [1:0] CFG_DIM_Z = 2'd3;

	typedef struct packed {
		logic store;
		logic start;
		logic step;
		logic finish;
	} vc3d_cmd_t;

	typedef struct packed {
		logic emit;
		logic last_tap;
		logic acc_done;
		logic out_busy;
	} vc3d_stat_t;
endpackage

// ----- src/vc3d_ram.sv -----
module vc3d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/vc3d_ctrl.sv -----
module vc3d_ctrl import vc3d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_type,
	output logic       in_ready,
	input  vc3d_stat_t stat,
	output vc3d_cmd_t  cmd
);
	typedef enum logic [1:0] {IDLE, RUN, DRAIN, FIN} state_t;
	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		cmd.store = in_valid && in_ready && (in_type == REQ_VOXEL);
		cmd.start = cmd.store && stat.emit;
		cmd.step = (state_q == RUN);
		cmd.finish = (state_q == FIN) && !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE:  if (cmd.start) state_q <= RUN;
				RUN:   if (stat.last_tap) state_q <= DRAIN;
				DRAIN: if (stat.acc_done) state_q <= FIN;
				FIN:   if (!stat.out_busy) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ----- src/vc3d_dp.sv -----
module vc3d_dp import vc3d_pkg::*; #(
	parameter int MAX_HALF   = 3,
	parameter int MAX_DIM    = 64,
	parameter int VOXEL_BITS = 24,
	parameter int COEF_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vc3d_cmd_t                    cmd,
	output vc3d_stat_t                   stat,
	input  logic                         load_we,
	input  logic [8:0]                   coef_index,
	input  logic [COEF_BITS-1:0]         coef_value,
	input  logic signed [VOXEL_BITS-1:0] voxel_value,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [6:0]                   cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [5:0]                   out_x,
	output logic [5:0]                   out_y,
	output logic [5:0]                   out_z,
	output logic signed [VOXEL_BITS-1:0] filtered_value,
	output logic                         is_last
);
	localparam int PLANES = 2 * MAX_HALF + 1;
	localparam int KDEPTH = PLANES * PLANES * PLANES;
	localparam int KW = $clog2(KDEPTH);
	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = $clog2(PLANES);
	localparam int HW = $clog2(MAX_HALF + 1);
	localparam int SDEPTH = PLANES * MAX_DIM * MAX_DIM;
	localparam int SW = $clog2(SDEPTH);
	localparam int PROD = VOXEL_BITS + COEF_BITS + 1;
	localparam int AW = 64;

	logic [HW-1:0] half_q;
	logic [DW-1:0] dx_q, dy_q, dz_q;
	logic [CW-1:0] px_q, py_q, pz_q;
	logic [PW-1:0] pl_q;

	function automatic logic [DW-1:0] clamp_dim(input logic [6:0] v);
		logic [DW-1:0] r;
		if (v == 7'd0) r = DW'(1);
		else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
		else r = DW'(v);
		return r;
	endfunction

	logic [HW:0] span;
	assign span = {half_q, 1'b0};

	logic xe, ye, ze;
	assign xe = (DW'(px_q) + DW'(1)) >= dx_q;
	assign ye = (DW'(py_q) + DW'(1)) >= dy_q;
	assign ze = (DW'(pz_q) + DW'(1)) >= dz_q;

	assign stat.emit = (px_q >= CW'(span)) && (py_q >= CW'(span)) && (pz_q >= CW'(span))
		&& (DW'(px_q) < dx_q) && (DW'(py_q) < dy_q) && (DW'(pz_q) < dz_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HW'(1);
			dx_q <= DW'(MAX_DIM);
			dy_q <= DW'(MAX_DIM);
			dz_q <= DW'(MAX_DIM);
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			pl_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF: half_q <= (32'(cfg_data[1:0]) > MAX_HALF) ? HW'(MAX_HALF)
					: HW'(cfg_data[1:0]);
				CFG_DIM_X: dx_q <= clamp_dim(cfg_data);
				CFG_DIM_Y: dy_q <= clamp_dim(cfg_data);
				CFG_DIM_Z: dz_q <= clamp_dim(cfg_data);
				default: half_q <= half_q;
			endcase
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			pl_q <= '0;
		end else if (cmd.store) begin
			if (xe) begin
				px_q <= '0;
				if (ye) begin
					py_q <= '0;
					if (ze) begin
						pz_q <= '0;
						pl_q <= '0;
					end else begin
						pz_q <= pz_q + CW'(1);
						pl_q <= (32'(pl_q) == PLANES - 1) ? '0 : pl_q + PW'(1);
					end
				end else begin
					py_q <= py_q + CW'(1);
				end
			end else begin
				px_q <= px_q + CW'(1);
			end
		end
	end

	// tap walk
	logic [HW:0] ta_q, tb_q, tc_q;
	logic [PW-1:0] tp_q;
	logic [CW-1:0] bx_q, by_q;
	logic [KW-1:0] tk_q;
	logic [5:0] ox_q, oy_q, oz_q;
	logic ol_q;
	logic tend;
	assign tend = (ta_q == span) && (tb_q == span) && (tc_q == span);
	assign stat.last_tap = tend;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ta_q <= '0;
			tb_q <= '0;
			tc_q <= '0;
			tk_q <= '0;
			bx_q <= px_q - CW'(span);
			by_q <= py_q - CW'(span);
			tp_q <= (32'(pl_q) >= 32'(span)) ? pl_q - PW'(span)
				: PW'(32'(pl_q) + PLANES - 32'(span));
			ox_q <= 6'(px_q - CW'(half_q));
			oy_q <= 6'(py_q - CW'(half_q));
			oz_q <= 6'(pz_q - CW'(half_q));
			ol_q <= xe && ye && ze;
		end else if (cmd.step && !tend) begin
			tk_q <= tk_q + KW'(1);
			if (ta_q == span) begin
				ta_q <= '0;
				if (tb_q == span) begin
					tb_q <= '0;
					tc_q <= tc_q + (HW+1)'(1);
					tp_q <= (32'(tp_q) == PLANES - 1) ? '0 : tp_q + PW'(1);
				end else begin
					tb_q <= tb_q + (HW+1)'(1);
				end
			end else begin
				ta_q <= ta_q + (HW+1)'(1);
			end
		end
	end

	logic [SW-1:0] waddr, raddr;
	logic [CW-1:0] rx, ry;
	assign rx = bx_q + CW'(ta_q);
	assign ry = by_q + CW'(tb_q);
	assign waddr = SW'(32'(pl_q) * MAX_DIM * MAX_DIM + 32'(py_q) * MAX_DIM + 32'(px_q));
	assign raddr = SW'(32'(tp_q) * MAX_DIM * MAX_DIM + 32'(ry) * MAX_DIM + 32'(rx));

	logic [VOXEL_BITS-1:0] vrd;
	logic [COEF_BITS-1:0] krd;

	vc3d_ram #(.WIDTH(VOXEL_BITS), .DEPTH(SDEPTH)) u_vox (
		.clk(clk), .we(cmd.store), .waddr(waddr), .wdata(voxel_value),
		.raddr(raddr), .rdata(vrd)
	);

	vc3d_ram #(.WIDTH(COEF_BITS), .DEPTH(KDEPTH)) u_ker (
		.clk(clk), .we(load_we && (32'(coef_index) < KDEPTH)), .waddr(KW'(coef_index)),
		.wdata(coef_value), .raddr(tk_q), .rdata(krd)
	);

	// read -> multiply -> accumulate
	logic v_s1, v_s2;
	logic signed [PROD-1:0] prod_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] sum;
	localparam logic signed [AW-1:0] LIM = AW'(1) <<< 62;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(vrd) * $signed({1'b0, krd});
	end

	assign sum = acc_q + AW'(prod_s2);
	assign stat.acc_done = !v_s1 && !v_s2;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			if (sum > LIM) acc_q <= LIM;
			else if (sum < -LIM) acc_q <= -LIM;
			else acc_q <= sum;
		end
	end

	// round half up and saturate
	logic signed [AW-1:0] rnd;
	logic signed [AW-1:0] q;
	logic signed [VOXEL_BITS-1:0] qs;
	localparam logic signed [AW-1:0] VMAX = (AW'(1) <<< (VOXEL_BITS - 1)) - AW'(1);
	localparam logic signed [AW-1:0] VMIN = -(AW'(1) <<< (VOXEL_BITS - 1));
	assign rnd = acc_q + (AW'(1) <<< (COEF_BITS - 1));
	assign q = rnd >>> COEF_BITS;
	assign qs = (q > VMAX) ? VOXEL_BITS'(VMAX) : (q < VMIN) ? VOXEL_BITS'(VMIN)
		: VOXEL_BITS'(q);

	assign stat.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_x <= ox_q;
			out_y <= oy_q;
			out_z <= oz_q;
			filtered_value <= qs;
			is_last <= ol_q;
		end
	end
endmodule

// ----- src/volume_convolution_3d_unit.sv -----
// Streaming 3-D convolution. Load kernel coefficients with req_type 0, then send
// voxels in raster order (x fastest). A voxel that completes an interior window
// keeps the block busy until its result is registered: one shared multiplier
// walks the window through the voxel memory read port, one tap a cycle, then
// the pipeline drains and the result is registered. The block stays busy longer
// while a finished result still waits at the output. Other items leave the block
// ready for the next item. Config writes restart the grid.
`include "assert_macros.svh"

module volume_convolution_3d_unit import vc3d_pkg::*; #(
	parameter int MAX_HALF   = 3,
	parameter int MAX_DIM    = 64,
	parameter int VOXEL_BITS = 24,
	parameter int COEF_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [8:0]                   coef_index,
	input  logic [COEF_BITS-1:0]         coef_value,
	input  logic signed [VOXEL_BITS-1:0] voxel_value,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [6:0]                   cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [5:0]                   out_x,
	output logic [5:0]                   out_y,
	output logic [5:0]                   out_z,
	output logic signed [VOXEL_BITS-1:0] filtered_value,
	output logic                         is_last
);
	vc3d_cmd_t  cmd;
	vc3d_stat_t stat;

	assign cfg_ready = 1'b1;

	vc3d_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_type(req_type),
		.in_ready(in_ready), .stat(stat), .cmd(cmd)
	);

	vc3d_dp #(
		.MAX_HALF(MAX_HALF), .MAX_DIM(MAX_DIM),
		.VOXEL_BITS(VOXEL_BITS), .COEF_BITS(COEF_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.load_we(in_valid && in_ready && (req_type == REQ_LOAD)),
		.coef_index(coef_index), .coef_value(coef_value), .voxel_value(voxel_value),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.filtered_value(filtered_value), .is_last(is_last)
	);

	`ASSERT_IMPL(a_start_idle, clk, arst_n, cmd.start, in_ready)
	`ASSERT_NEXT(a_busy_after_start, clk, arst_n, cmd.start, !in_ready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

// ----- bench/volume_convolution_3d_unit_test.sv -----
`timescale 1ns / 1ps

module volume_convolution_3d_unit_test;
	import vc3d_pkg::*;

	localparam int PLANES = 7;
	localparam int PLANE_WORDS = 64 * 64;
	localparam int KERNEL_WORDS = 343;

	typedef struct {
		logic [5:0]         x;
		logic [5:0]         y;
		logic [5:0]         z;
		logic signed [23:0] value;
		logic               last;
	} filtered_voxel_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [8:0]         coef_index;
	logic [15:0]        coef_value;
	logic signed [23:0] voxel_value;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [6:0]         cfg_data;
	logic               out_valid;
	logic               out_ready;
	logic [5:0]         out_x;
	logic [5:0]         out_y;
	logic [5:0]         out_z;
	logic signed [23:0] filtered_value;
	logic               is_last;

	// shadow copy of the filter state
	logic signed [23:0] plane_mem [PLANES * PLANE_WORDS];
	int unsigned        kernel_mem [KERNEL_WORDS];
	int                 cur_x, cur_y, cur_z;
	int                 half_sz, size_x, size_y, size_z;

	filtered_voxel_t    pending_voxels [$];
	int                 error_count;
	int                 sent_count;
	bit                 send_quiet;
	bit                 recv_quiet;

	volume_convolution_3d_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.coef_index     (coef_index),
		.coef_value     (coef_value),
		.voxel_value    (voxel_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.filtered_value (filtered_value),
		.is_last        (is_last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int clamp_size(input logic [6:0] d);
		if (d == 0)
			return 1;
		if (d > 64)
			return 64;
		return d;
	endfunction

	// stores a coefficient or steps the grid, queuing a result if a window fills
	function automatic void convolve_request(input logic kind, input logic [8:0] idx,
			input logic [15:0] coef, input logic signed [23:0] vox);
		int x, y, z, side, span, k, addr;
		bit emit, last;
		longint acc, q;
		filtered_voxel_t r;
		if (kind == REQ_LOAD) begin
			if (idx < KERNEL_WORDS)
				kernel_mem[idx] = coef;
			return;
		end
		x = cur_x;
		y = cur_y;
		z = cur_z;
		side = 2 * half_sz + 1;
		span = 2 * half_sz;
		plane_mem[(z % PLANES) * PLANE_WORDS + y * 64 + x] = vox;
		emit = x >= span && y >= span && z >= span && x < size_x && y < size_y && z < size_z;
		last = (x + 1 >= size_x) && (y + 1 >= size_y) && (z + 1 >= size_z);
		if (x + 1 >= size_x) begin
			cur_x = 0;
			if (y + 1 >= size_y) begin
				cur_y = 0;
				cur_z = (z + 1 >= size_z) ? 0 : z + 1;
			end else begin
				cur_y = y + 1;
			end
		end else begin
			cur_x = x + 1;
		end
		if (!emit)
			return;
		acc = 0;
		for (int c = 0; c < side; c++) begin
			for (int b = 0; b < side; b++) begin
				for (int a = 0; a < side; a++) begin
					k = (c * side + b) * side + a;
					addr = ((z - span + c) % PLANES) * PLANE_WORDS + (y - span + b) * 64
						+ (x - span + a);
					acc += longint'(plane_mem[addr]) * longint'(kernel_mem[k]);
				end
			end
		end
		q = (acc + 64'sd32768) >>> 16;
		if (q > 64'sd8388607)
			q = 64'sd8388607;
		if (q < -64'sd8388608)
			q = -64'sd8388608;
		r.x = 6'(x - half_sz);
		r.y = 6'(y - half_sz);
		r.z = 6'(z - half_sz);
		r.value = q[23:0];
		r.last = last;
		pending_voxels.push_back(r);
	endfunction

	task automatic send_request(input logic kind, input logic [8:0] idx,
			input logic [15:0] coef, input logic signed [23:0] vox);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		convolve_request(kind, idx, coef, vox);
		in_valid <= 1'b1;
		req_type <= kind;
		coef_index <= idx;
		coef_value <= coef;
		voxel_value <= vox;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic wait_drained();
		while (pending_voxels.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_config(input logic [1:0] idx, input logic [6:0] data);
		in_valid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_HALF:  half_sz = data[1:0];
			CFG_DIM_X: size_x = clamp_size(data);
			CFG_DIM_Y: size_y = clamp_size(data);
			CFG_DIM_Z: size_z = clamp_size(data);
		endcase
		cur_x = 0;
		cur_y = 0;
		cur_z = 0;
		@(posedge clk);
	endtask

	task automatic set_grid(input int h, input logic [6:0] dx, input logic [6:0] dy,
			input logic [6:0] dz);
		write_config(CFG_HALF, 7'(h) | 7'($urandom_range(0, 31) << 2));
		write_config(CFG_DIM_X, dx);
		write_config(CFG_DIM_Y, dy);
		write_config(CFG_DIM_Z, dz);
	endtask

	task automatic send_voxel(input logic signed [23:0] vox);
		send_request(REQ_VOXEL, 9'($urandom), 16'($urandom), vox);
	endtask

	task automatic send_coef(input logic [8:0] idx, input logic [15:0] coef);
		send_request(REQ_LOAD, idx, coef, 24'($urandom));
	endtask

	function automatic logic signed [23:0] random_voxel(input int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'sd8388607 - 24'($urandom_range(0, 65535));
			2: return -24'sd8388608 + 24'($urandom_range(0, 65535));
			default: return 24'($signed(12'($urandom)));
		endcase
	endfunction

	task automatic test_kernel_load();
		for (int i = 0; i < KERNEL_WORDS; i++)
			send_coef(9'(i), (i % 3 == 0) ? 16'hffff : (i % 3 == 1) ? 16'h0000
				: 16'($urandom));
		// out of range entries are dropped
		send_coef(9'd343, 16'h1234);
		send_coef(9'd511, 16'hffff);
	endtask

	task automatic test_edges();
		// single tap kernel, every voxel is interior
		set_grid(0, 7'd2, 7'd0, 7'd1);
		send_coef(9'd0, 16'hffff);
		send_voxel(24'sd8388607);
		send_voxel(-24'sd8388608);
		send_voxel(24'sd1);
		send_voxel(-24'sd1);
		send_coef(9'd0, 16'h8000);
		send_voxel(24'sd3);
		send_voxel(-24'sd3);
		// oversized axis is cut to the maximum
		write_config(CFG_DIM_X, 7'd127);
		send_voxel(24'sd255);
		send_voxel(-24'sd255);
		// grid smaller than the window
		set_grid(1, 7'd2, 7'd3, 7'd3);
		repeat (5) send_voxel(24'($urandom));
	endtask

	task automatic test_saturation();
		set_grid(1, 7'd3, 7'd3, 7'd3);
		for (int i = 0; i < 27; i++)
			send_coef(9'(i), 16'hffff);
		repeat (27) send_voxel(24'sd8388607);
	endtask

	task automatic run_grid(input int h, input int dx, input int dy, input int dz,
			input int passes, input bit pause_mid);
		int side, mode, total;
		side = 2 * h + 1;
		set_grid(h, 7'(dx), 7'(dy), 7'(dz));
		for (int k = 0; k < side * side * side; k++)
			if ($urandom_range(0, 3) == 0)
				send_coef(9'(k), ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom));
		mode = $urandom_range(0, 5);
		total = dx * dy * dz * passes;
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 40) == 0)
				send_coef(9'($urandom_range(0, side * side * side - 1)), 16'($urandom));
			if (pause_mid && i == total / 2) begin
				in_valid <= 1'b0;
				while (pending_voxels.size() != 0)
					@(posedge clk);
			end
			send_voxel(random_voxel(mode));
		end
	endtask

	task automatic test_pause();
		run_grid(1, 4, 4, 4, 1, 1'b1);
	endtask

	task automatic test_random();
		int h, side, lo;
		while (sent_count < 1600) begin
			send_quiet = $urandom_range(0, 4) == 0;
			recv_quiet = $urandom_range(0, 4) == 0;
			h = $urandom_range(0, 5);
			if (h > 3)
				h = 1;
			side = 2 * h + 1;
			lo = (h == 3) ? 7 : side;
			if ($urandom_range(0, 9) == 0)
				run_grid(h, $urandom_range(1, side), $urandom_range(1, 3), 1, 1, 1'b0);
			else if (h == 3)
				run_grid(h, $urandom_range(lo, 8), $urandom_range(lo, 8), 7, 1, 1'b0);
			else
				run_grid(h, $urandom_range(lo, lo + 4), $urandom_range(lo, lo + 3),
					$urandom_range(lo, lo + 2), $urandom_range(1, 2), 1'b0);
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = recv_quiet ? 0 : $urandom_range(0, 6);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		filtered_voxel_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_voxels.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d value=%0d", $time,
					out_x, out_y, out_z, filtered_value);
				error_count++;
			end else begin
				e = pending_voxels.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z) begin
					$display("%0t: coordinate mismatch expected %0d,%0d,%0d got %0d,%0d,%0d",
						$time, e.x, e.y, e.z, out_x, out_y, out_z);
					error_count++;
				end
				if (filtered_value !== e.value) begin
					$display("%0t: filtered_value expected %0d got %0d", $time, e.value,
						filtered_value);
					error_count++;
				end
				if (is_last !== e.last) begin
					$display("%0t: is_last expected %0b got %0b", $time, e.last, is_last);
					error_count++;
				end
			end
		end
	end

	initial begin
		#50000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		coef_index = '0;
		coef_value = '0;
		voxel_value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HALF;
		cfg_data = '0;
		error_count = 0;
		sent_count = 0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		half_sz = 1;
		size_x = 64;
		size_y = 64;
		size_z = 64;
		cur_x = 0;
		cur_y = 0;
		cur_z = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_kernel_load();
		test_edges();
		test_saturation();
		test_pause();
		test_random();
		in_valid <= 1'b0;
		while (pending_voxels.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
